### sv/gdhcd_pkg.sv
package gdhcd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;

  // Shifted year y = year + 400 and p = y - 1 both stay below 2**15.
  localparam int P_W = YEAR_W + 1;

  // Division by 100 as a multiply by a reciprocal: exact for every value below 2**15.
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int MUL_W       = P_W + RECIP_W;
  localparam int Q_W         = MUL_W - RECIP_SHIFT;

  localparam int ERA_YEARS   = 400;
  localparam int YEAR_DAYS   = 365;
  localparam int DAY_HOURS   = 24;
  localparam int CENTURY     = 100;

  localparam int DAYS_W  = 23;
  localparam int HOURS_W = 28;
  localparam int DIFF_W  = HOURS_W + 1;
  localparam int OUT_W   = 28;

  localparam logic signed [DIFF_W-1:0] DIFF_LIMIT = DIFF_W'(87649439);

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = HOUR_W'(23);

  // Days before the first of each month in a common year; codes outside 1..12 give 0.
  localparam logic [8:0] CUM_DAYS [0:15] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
  };

  // Lane conversion takes three stages, the merge two more.
  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  typedef struct packed {
    logic err;
    logic eq;
    logic lt;
  } cmp_flags_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] hours_difference;
    logic                    is_equal;
    logic                    is_before;
    logic                    is_before_or_equal;
    logic                    input_error;
  } result_t;

endpackage

### sv/gdhcd_if.sv
interface gdhcd_req_if;
  logic        valid;
  logic        ready;
  logic [13:0] first_year;
  logic [3:0]  first_month;
  logic [4:0]  first_day;
  logic [4:0]  first_hour;
  logic [13:0] second_year;
  logic [3:0]  second_month;
  logic [4:0]  second_day;
  logic [4:0]  second_hour;

  modport source (
    output valid, first_year, first_month, first_day, first_hour,
           second_year, second_month, second_day, second_hour,
    input  ready
  );
  modport sink (
    input  valid, first_year, first_month, first_day, first_hour,
           second_year, second_month, second_day, second_hour,
    output ready
  );
endinterface

interface gdhcd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [27:0] hours_difference;
  logic               is_equal;
  logic               is_before;
  logic               is_before_or_equal;
  logic               input_error;

  modport source (
    output valid, hours_difference, is_equal, is_before, is_before_or_equal,
           input_error,
    input  ready
  );
  modport sink (
    input  valid, hours_difference, is_equal, is_before, is_before_or_equal,
           input_error,
    output ready
  );
endinterface

### sv/gdhcd_lane.sv
module gdhcd_lane (
  input  logic                         clk,
  input  gdhcd_pkg::pipe_ctl_t         ctl,
  input  logic [gdhcd_pkg::YEAR_W-1:0]  year,
  input  logic [gdhcd_pkg::MONTH_W-1:0] month,
  input  logic [gdhcd_pkg::DAY_W-1:0]   day,
  input  logic [gdhcd_pkg::HOUR_W-1:0]  hour,
  output logic [gdhcd_pkg::HOURS_W-1:0] hours
);
  import gdhcd_pkg::*;

  logic [P_W-1:0]     y_in;
  logic [P_W-1:0]     p_in;

  // Stage 1: shifted year and the two reciprocal products.
  logic [P_W-1:0]     s1_y;
  logic [P_W-1:0]     s1_p;
  logic [MUL_W-1:0]   s1_my;
  logic [MUL_W-1:0]   s1_mp;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic [HOUR_W-1:0]  s1_hour;

  // Stage 2: day count.
  logic [Q_W-1:0]     qy;
  logic [Q_W-1:0]     qp;
  logic [P_W-1:0]     ry;
  logic               leap;
  logic               leap_bump;
  logic [DAYS_W-1:0]  days_next;
  logic [DAYS_W-1:0]  s2_days;
  logic [HOUR_W-1:0]  s2_hour;

  assign y_in = P_W'(year) + P_W'(ERA_YEARS);
  assign p_in = y_in - P_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_y     <= y_in;
      s1_p     <= p_in;
      s1_my    <= MUL_W'(y_in) * MUL_W'(RECIP_100);
      s1_mp    <= MUL_W'(p_in) * MUL_W'(RECIP_100);
      s1_month <= month;
      s1_day   <= day;
      s1_hour  <= hour;
    end
  end

  assign qy = s1_my[MUL_W-1:RECIP_SHIFT];
  assign qp = s1_mp[MUL_W-1:RECIP_SHIFT];
  assign ry = s1_y - P_W'(qy) * P_W'(CENTURY);

  // A century year is leap only when its century count is a multiple of four.
  assign leap      = (ry == '0) ? (qy[1:0] == 2'b00) : (s1_y[1:0] == 2'b00);
  assign leap_bump = leap && (s1_month > MONTH_FEB);

  assign days_next = DAYS_W'(s1_p) * DAYS_W'(YEAR_DAYS) + DAYS_W'(s1_p >> 2)
                   - DAYS_W'(qp) + DAYS_W'(qp >> 2) + DAYS_W'(CUM_DAYS[s1_month])
                   + DAYS_W'(leap_bump) + DAYS_W'(s1_day) - DAYS_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_days <= days_next;
      s2_hour <= s1_hour;
    end
  end

  // Stage 3: hours since the shifted epoch.
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      hours <= HOURS_W'(s2_days) * HOURS_W'(DAY_HOURS) + HOURS_W'(s2_hour);
    end
  end

endmodule

### sv/gdhcd_merge.sv
module gdhcd_merge (
  input  logic                          clk,
  input  gdhcd_pkg::pipe_ctl_t          ctl,
  input  logic [gdhcd_pkg::YEAR_W-1:0]  first_year,
  input  logic [gdhcd_pkg::MONTH_W-1:0] first_month,
  input  logic [gdhcd_pkg::DAY_W-1:0]   first_day,
  input  logic [gdhcd_pkg::HOUR_W-1:0]  first_hour,
  input  logic [gdhcd_pkg::YEAR_W-1:0]  second_year,
  input  logic [gdhcd_pkg::MONTH_W-1:0] second_month,
  input  logic [gdhcd_pkg::DAY_W-1:0]   second_day,
  input  logic [gdhcd_pkg::HOUR_W-1:0]  second_hour,
  input  logic [gdhcd_pkg::HOURS_W-1:0] first_hours,
  input  logic [gdhcd_pkg::HOURS_W-1:0] second_hours,
  output gdhcd_pkg::result_t            result
);
  import gdhcd_pkg::*;

  logic                     bad_first;
  logic                     bad_second;
  cmp_flags_t               flags_in;
  cmp_flags_t               s1_flags;
  cmp_flags_t               s2_flags;
  cmp_flags_t               s3_flags;
  cmp_flags_t               s4_flags;
  logic signed [DIFF_W-1:0] s4_diff;
  logic signed [OUT_W-1:0]  sat_diff;

  assign bad_first  = (first_month == '0) || (first_month > MONTH_DEC)
                   || (first_day == '0) || (first_hour > HOUR_MAX);
  assign bad_second = (second_month == '0) || (second_month > MONTH_DEC)
                   || (second_day == '0) || (second_hour > HOUR_MAX);

  // Concatenating the fields most significant first gives the calendar order.
  assign flags_in.err = bad_first || bad_second;
  assign flags_in.eq  = {first_year, first_month, first_day, first_hour}
                     == {second_year, second_month, second_day, second_hour};
  assign flags_in.lt  = {first_year, first_month, first_day, first_hour}
                     <  {second_year, second_month, second_day, second_hour};

  always_ff @(posedge clk) begin
    if (ctl.load[0]) s1_flags <= flags_in;
    if (ctl.load[1]) s2_flags <= s1_flags;
    if (ctl.load[2]) s3_flags <= s2_flags;
    if (ctl.load[3]) begin
      s4_flags <= s3_flags;
      s4_diff  <= $signed({1'b0, first_hours}) - $signed({1'b0, second_hours});
    end
  end

  always_comb begin
    if (s4_diff > DIFF_LIMIT) begin
      sat_diff = OUT_W'(DIFF_LIMIT);
    end else if (s4_diff < -DIFF_LIMIT) begin
      sat_diff = OUT_W'(-DIFF_LIMIT);
    end else begin
      sat_diff = s4_diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      result.hours_difference   <= s4_flags.err ? '0 : sat_diff;
      result.is_equal           <= !s4_flags.err && s4_flags.eq;
      result.is_before          <= !s4_flags.err && s4_flags.lt;
      result.is_before_or_equal <= !s4_flags.err && (s4_flags.eq || s4_flags.lt);
      result.input_error        <= s4_flags.err;
    end
  end

endmodule

### sv/gregorian_date_hour_compare_diff.sv
// An accepted beat runs through two parallel conversion lanes, then the merge, to rsp.
// Throughput: one date pair per cycle unless rsp stalls; each lane is a three-stage
// pipeline, followed by a two-stage difference and saturation merge.
// req.ready stays high while any stage, output register included, is empty or moving.
// Synchronous reset clears the stage valid bits; the data registers are not reset.
module gregorian_date_hour_compare_diff (
  input  logic        clk,
  input  logic        rst,
  gdhcd_req_if.sink   req,
  gdhcd_rsp_if.source rsp
);
  import gdhcd_pkg::*;

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] advance;
  pipe_ctl_t             ctl;
  logic [HOURS_W-1:0]    first_hours;
  logic [HOURS_W-1:0]    second_hours;
  result_t               result;

  // A stage may load when it is empty or its contents move on in the same cycle.
  always_comb begin
    advance[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || rsp.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      advance[k] = !stage_valid[k] || advance[k+1];
    end
  end

  assign ctl.load  = advance;
  assign req.ready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (advance[0]) stage_valid[0] <= req.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (advance[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  gdhcd_lane u_lane_first (
    .clk   (clk),
    .ctl   (ctl),
    .year  (req.first_year),
    .month (req.first_month),
    .day   (req.first_day),
    .hour  (req.first_hour),
    .hours (first_hours)
  );

  gdhcd_lane u_lane_second (
    .clk   (clk),
    .ctl   (ctl),
    .year  (req.second_year),
    .month (req.second_month),
    .day   (req.second_day),
    .hour  (req.second_hour),
    .hours (second_hours)
  );

  gdhcd_merge u_merge (
    .clk          (clk),
    .ctl          (ctl),
    .first_year   (req.first_year),
    .first_month  (req.first_month),
    .first_day    (req.first_day),
    .first_hour   (req.first_hour),
    .second_year  (req.second_year),
    .second_month (req.second_month),
    .second_day   (req.second_day),
    .second_hour  (req.second_hour),
    .first_hours  (first_hours),
    .second_hours (second_hours),
    .result       (result)
  );

  assign rsp.valid              = stage_valid[NUM_STAGES-1];
  assign rsp.hours_difference   = result.hours_difference;
  assign rsp.is_equal           = result.is_equal;
  assign rsp.is_before          = result.is_before;
  assign rsp.is_before_or_equal = result.is_before_or_equal;
  assign rsp.input_error        = result.input_error;

endmodule

### dv/date_check_pkg.sv
`timescale 1ns / 1ps
package date_check_pkg;
  import gdhcd_pkg::*;

  localparam longint HOURS_SPAN = 87649439;

  // Days before the first of each month in a common year, indexed by month code.
  localparam int MONTH_START [0:15] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [HOUR_W-1:0]  first_hour;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic [HOUR_W-1:0]  second_hour;
  } date_pair_t;

  class date_pair_scoreboard;
    result_t expected_results[$];
    int failures;
    int n_checked;
    int n_error;
    int n_clipped;
    int n_equal;
    int n_before;

    static function bit is_leap(longint y);
      return (y % ERA_YEARS == 0) || ((y % CENTURY != 0) && (y % 4 == 0));
    endfunction

    static function bit fields_bad(logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
                                   logic [HOUR_W-1:0] h);
      return (m == 0) || (m > MONTH_DEC) || (d == 0) || (h > HOUR_MAX);
    endfunction

    // Hours since an epoch 400 years before year 1; the shift cancels in a difference
    // and keeps year 0 and its leap day on the positive side.
    static function longint elapsed_hours(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                          logic [DAY_W-1:0] d, logic [HOUR_W-1:0] h);
      longint shifted;
      longint p;
      longint days;
      shifted = longint'(y) + ERA_YEARS;
      p = shifted - 1;
      days = YEAR_DAYS * p + p / 4 - p / CENTURY + p / ERA_YEARS
             + MONTH_START[m] + longint'(d) - 1;
      if (m > MONTH_FEB && is_leap(shifted)) days++;
      return days * DAY_HOURS + longint'(h);
    endfunction

    function void note_pair(date_pair_t p);
      result_t r;
      longint diff;
      bit err;
      bit lt;
      r = '0;
      lt = 1'b0;
      err = fields_bad(p.first_month, p.first_day, p.first_hour) ||
            fields_bad(p.second_month, p.second_day, p.second_hour);
      if (!err) begin
        diff = elapsed_hours(p.first_year, p.first_month, p.first_day, p.first_hour) -
               elapsed_hours(p.second_year, p.second_month, p.second_day, p.second_hour);
        if (diff > HOURS_SPAN || diff < -HOURS_SPAN) begin
          n_clipped++;
          diff = (diff > 0) ? HOURS_SPAN : -HOURS_SPAN;
        end
        r.is_equal = (p.first_year == p.second_year) && (p.first_month == p.second_month) &&
                     (p.first_day == p.second_day) && (p.first_hour == p.second_hour);
        // Ordering is on the fields themselves, so an overlong day can disagree
        // with the sign of the difference.
        if (p.first_year != p.second_year) lt = p.first_year < p.second_year;
        else if (p.first_month != p.second_month) lt = p.first_month < p.second_month;
        else if (p.first_day != p.second_day) lt = p.first_day < p.second_day;
        else lt = p.first_hour < p.second_hour;
        r.hours_difference = diff[OUT_W-1:0];
        r.is_before = lt;
        r.is_before_or_equal = lt | r.is_equal;
      end
      r.input_error = err;
      if (err) n_error++;
      if (r.is_equal) n_equal++;
      if (r.is_before) n_before++;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [OUT_W-1:0] want,
                                logic signed [OUT_W-1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing expected, got difference %0d",
                 $time, got.hours_difference);
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      compare_field("hours_difference", want.hours_difference, got.hours_difference);
      compare_field("is_equal", want.is_equal, got.is_equal);
      compare_field("is_before", want.is_before, got.is_before);
      compare_field("is_before_or_equal", want.is_before_or_equal, got.is_before_or_equal);
      compare_field("input_error", want.input_error, got.input_error);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

### dv/tb_gregorian_date_hour_compare_diff.sv
`timescale 1ns / 1ps
module tb_gregorian_date_hour_compare_diff;
  import gdhcd_pkg::*;
  import date_check_pkg::*;

  localparam int QUIET_LIMIT     = 1000;
  localparam int RSP_HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;

  gdhcd_req_if req ();
  gdhcd_rsp_if rsp ();

  gregorian_date_hour_compare_diff uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  date_pair_scoreboard sb;
  bit tx_steady;
  bit rsp_steady;
  int hold_asks = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic date_pair_t mk(int y1, int m1, int d1, int h1,
                                    int y2, int m2, int d2, int h2);
    date_pair_t p;
    p.first_year   = YEAR_W'(y1);
    p.first_month  = MONTH_W'(m1);
    p.first_day    = DAY_W'(d1);
    p.first_hour   = HOUR_W'(h1);
    p.second_year  = YEAR_W'(y2);
    p.second_month = MONTH_W'(m2);
    p.second_day   = DAY_W'(d2);
    p.second_hour  = HOUR_W'(h2);
    return p;
  endfunction

  function automatic logic [YEAR_W-1:0] random_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return YEAR_W'($urandom_range(1, 9999));
    if (r < 95) return YEAR_W'($urandom_range(0, 16383));
    case ($urandom_range(0, 3))
      0: return YEAR_W'(0);
      1: return YEAR_W'(1);
      2: return YEAR_W'(9999);
      default: return YEAR_W'(16383);
    endcase
  endfunction

  // Mostly well-formed pairs, a good share of them close together so that the
  // ordering flags are exercised field by field; the rest is raw noise.
  function automatic date_pair_t random_pair();
    date_pair_t p;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      p.first_year   = YEAR_W'($urandom);
      p.first_month  = MONTH_W'($urandom);
      p.first_day    = DAY_W'($urandom);
      p.first_hour   = HOUR_W'($urandom);
      p.second_year  = YEAR_W'($urandom);
      p.second_month = MONTH_W'($urandom);
      p.second_day   = DAY_W'($urandom);
      p.second_hour  = HOUR_W'($urandom);
      return p;
    end
    p = mk(random_year(), $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
           random_year(), $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23));
    if (r < 40) begin
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
      p.second_day   = p.first_day;
      p.second_hour  = p.first_hour;
      if (r >= 15) begin
        case ($urandom_range(0, 3))
          0: p.second_year = p.first_year + YEAR_W'($urandom_range(0, 2)) - YEAR_W'(1);
          1: p.second_month = MONTH_W'($urandom_range(1, 12));
          2: p.second_day = DAY_W'($urandom_range(1, 31));
          default: p.second_hour = HOUR_W'($urandom_range(0, 23));
        endcase
      end
    end
    return p;
  endfunction

  task automatic offer_pair(input date_pair_t p);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.first_year   <= p.first_year;
    req.first_month  <= p.first_month;
    req.first_day    <= p.first_day;
    req.first_hour   <= p.first_hour;
    req.second_year  <= p.second_year;
    req.second_month <= p.second_month;
    req.second_day   <= p.second_day;
    req.second_hour  <= p.second_hour;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic random_run(input int count);
    repeat (count) offer_pair(random_pair());
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, or one long hold-off that backs the pipeline up.
  initial begin : rsp_side
    int n;
    bit v;
    int holds_done;
    holds_done = 0;
    forever begin
      if (holds_done != hold_asks) begin
        v = 1'b0;
        n = RSP_HOLD_CYCLES;
        holds_done++;
      end else if (rsp_steady) begin
        v = 1'b1;
        n = 1;
      end else begin
        v = ($urandom_range(0, 3) != 0);
        n = idle_len() + 1;
      end
      rsp.ready <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_pair(date_pair_t'{first_year: req.first_year, first_month: req.first_month,
                                first_day: req.first_day, first_hour: req.first_hour,
                                second_year: req.second_year,
                                second_month: req.second_month,
                                second_day: req.second_day, second_hour: req.second_hour});
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(result_t'{hours_difference: rsp.hours_difference,
                                is_equal: rsp.is_equal, is_before: rsp.is_before,
                                is_before_or_equal: rsp.is_before_or_equal,
                                input_error: rsp.input_error});
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    tx_steady  = 1'b1;
    rsp_steady = 1'b1;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.first_year   <= '0;
    req.first_month  <= '0;
    req.first_day    <= '0;
    req.first_hour   <= '0;
    req.second_year  <= '0;
    req.second_month <= '0;
    req.second_day   <= '0;
    req.second_hour  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Extremes, leap rules, field-by-field ordering and every kind of bad field.
    offer_pair(mk(1, 1, 1, 0, 1, 1, 1, 0));
    offer_pair(mk(9999, 12, 31, 23, 1, 1, 1, 0));
    offer_pair(mk(1, 1, 1, 0, 9999, 12, 31, 23));
    offer_pair(mk(16383, 12, 31, 23, 0, 1, 1, 0));
    offer_pair(mk(0, 1, 1, 0, 16383, 12, 31, 23));
    offer_pair(mk(16383, 12, 31, 23, 16383, 12, 31, 23));
    offer_pair(mk(16383, 1, 1, 0, 16382, 12, 31, 23));
    offer_pair(mk(0, 3, 1, 0, 0, 2, 28, 0));
    offer_pair(mk(2000, 3, 1, 0, 2000, 2, 28, 0));
    offer_pair(mk(1900, 3, 1, 0, 1900, 2, 28, 0));
    offer_pair(mk(2024, 3, 1, 5, 2023, 3, 1, 5));
    offer_pair(mk(2023, 2, 31, 0, 2023, 3, 3, 0));
    offer_pair(mk(2024, 6, 15, 10, 2024, 6, 15, 11));
    offer_pair(mk(2024, 6, 15, 10, 2024, 6, 14, 10));
    offer_pair(mk(2024, 5, 15, 10, 2024, 6, 15, 10));
    offer_pair(mk(2025, 1, 1, 0, 2024, 12, 31, 23));
    offer_pair(mk(2024, 0, 1, 0, 2024, 1, 1, 0));
    offer_pair(mk(2024, 1, 1, 0, 2024, 13, 1, 0));
    offer_pair(mk(2024, 15, 31, 31, 2024, 15, 31, 31));
    offer_pair(mk(2024, 1, 0, 0, 2024, 1, 1, 0));
    offer_pair(mk(2024, 1, 1, 0, 2024, 1, 0, 0));
    offer_pair(mk(2024, 1, 1, 24, 2024, 1, 1, 0));
    offer_pair(mk(2024, 1, 1, 0, 2024, 1, 1, 31));
    drain_results();

    tx_steady  = 1'b0;
    rsp_steady = 1'b0;
    random_run(500);
    drain_results();

    // Keep offering beats back to back while the result side holds off.
    tx_steady = 1'b1;
    hold_asks++;
    random_run(300);
    drain_results();

    tx_steady = 1'b0;
    random_run(600);
    drain_results();

    tx_steady = 1'b1;
    random_run(527);
    drain_results();

    repeat (2 * NUM_STAGES) @(posedge clk);
    $display("Checked %0d date pairs: %0d with bad fields, %0d clipped differences.",
             sb.n_checked, sb.n_error, sb.n_clipped);
    $display("Ordering seen: %0d equal pairs, %0d with the first date earlier.",
             sb.n_equal, sb.n_before);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
